### design/btd_pkg.sv
// shared types, constants and glyph table of the packed text decoder
package btd_pkg;

  // one compressed byte and its string start flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_string;
  } in_item_t;

  // one decoded result
  typedef struct packed {
    logic [6:0] char_code;
    logic       char_valid;
    logic       string_end;
    logic       last_of_run;
  } out_item_t;

  // results of one byte handed from the decoder to the result queue
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  // escape state
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_SHOW = 2'd1,
    ESC_HIDE = 2'd2
  } esc_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int GLYPH_COUNT = 92;

  localparam logic [6:0] SHIFT_CODE = 7'h1E;
  localparam logic [6:0] EXT_CODE   = 7'h1F;
  localparam logic [6:0] MARK_SHOW  = 7'h2F;
  localparam logic [6:0] MARK_HIDE  = 7'h5C;
  localparam logic [7:0] SHIFT_HIT  = 8'h40;
  localparam logic [7:0] LOWER_LO   = 8'hE1;
  localparam logic [7:0] LOWER_HI   = 8'hFA;
  localparam logic [7:0] UPPER_MASK = 8'hDF;

  // glyph table, entry k serves code k+1
  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT] = '{
    8'ha0, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf0, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf9, 8'hae,
    8'ha2, 8'ha7, 8'hac, 8'ha1, 8'h8d, 8'hea, 8'hf1, 8'hf8, 8'hfa, 8'hb0, 8'hb1, 8'hb2,
    8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
    8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'ha8, 8'ha9, 8'haf, 8'hdc, 8'ha3,
    8'haa, 8'hbf, 8'hbc, 8'hbe, 8'hba, 8'hbb, 8'had, 8'ha5
  };

endpackage

### design/btd_decode.sv
// input register, decode state and single pass byte decoder
module btd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  btd_pkg::in_item_t in_data,
  input  logic              room,
  output btd_pkg::push_t    push
);

  btd_pkg::in_item_t in_item_r;
  logic              in_full_r;
  logic              fire;

  logic [5:0]        pc_r, pc_nxt;
  logic [2:0]        bc_r, bc_nxt;
  logic              ext_r, ext_nxt;
  logic [7:0]        cs_r, cs_nxt;
  btd_pkg::esc_t     esc_r, esc_nxt;

  // item leaves the input register when the queue can take two results
  assign fire     = in_full_r & room;
  assign in_stall = in_full_r & ~fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full_r <= 1'b1;
    end else if (fire) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      bc_r  <= '0;
      ext_r <= 1'b0;
      cs_r  <= '0;
      esc_r <= btd_pkg::ESC_NONE;
    end else if (fire) begin
      pc_r  <= pc_nxt;
      bc_r  <= bc_nxt;
      ext_r <= ext_nxt;
      cs_r  <= cs_nxt;
      esc_r <= esc_nxt;
    end
  end

  // walk the eight bits msb first, at most two results come out
  always_comb begin
    logic                 done;
    logic                 was_ext;
    logic                 emit;
    logic [6:0]           code;
    logic [7:0]           glyph;
    logic [6:0]           ch;
    btd_pkg::out_item_t   res;

    pc_nxt  = in_item_r.new_string ? 6'd0 : pc_r;
    bc_nxt  = in_item_r.new_string ? 3'd0 : bc_r;
    ext_nxt = in_item_r.new_string ? 1'b0 : ext_r;
    cs_nxt  = in_item_r.new_string ? 8'd0 : cs_r;
    esc_nxt = in_item_r.new_string ? btd_pkg::ESC_NONE : esc_r;
    push    = '0;
    done    = 1'b0;
    was_ext = 1'b0;
    emit    = 1'b0;
    code    = '0;
    glyph   = '0;
    ch      = '0;
    res     = '0;

    for (int pos = 7; pos >= 0; pos--) begin
      emit = 1'b0;
      res  = '0;
      if (!done) begin
        pc_nxt = {pc_nxt[4:0], in_item_r.data_byte[3'(pos)]};
        bc_nxt = bc_nxt + 3'd1;
        if (ext_nxt ? (bc_nxt == 3'd6) : (bc_nxt == 3'd5)) begin
          was_ext = ext_nxt;
          code    = was_ext ? ({1'b0, pc_nxt} + btd_pkg::SHIFT_CODE) : {1'b0, pc_nxt};
          pc_nxt  = '0;
          bc_nxt  = '0;
          ext_nxt = 1'b0;
          if (!was_ext && code == btd_pkg::SHIFT_CODE) begin
            // case shift
            cs_nxt = {1'b1, cs_nxt[7:1]};
          end else if (!was_ext && code == btd_pkg::EXT_CODE) begin
            // extension prefix
            ext_nxt = 1'b1;
          end else if (code == 7'd0 || code > 7'(btd_pkg::GLYPH_COUNT)) begin
            // end of string: report and drop the rest of the byte
            res.string_end = 1'b1;
            emit    = 1'b1;
            done    = 1'b1;
            cs_nxt  = '0;
            esc_nxt = btd_pkg::ESC_NONE;
          end else begin
            glyph  = btd_pkg::GLYPH_ROM[code - 7'd1];
            cs_nxt = {1'b0, cs_nxt[7:1]};
            if (cs_nxt >= btd_pkg::SHIFT_HIT && glyph >= btd_pkg::LOWER_LO &&
                glyph <= btd_pkg::LOWER_HI) begin
              glyph = glyph & btd_pkg::UPPER_MASK;
            end
            ch = glyph[6:0];
            res.char_code  = ch;
            res.char_valid = 1'b1;
            // escape markers
            case (esc_nxt)
              btd_pkg::ESC_NONE: begin
                if (ch == btd_pkg::MARK_SHOW) begin
                  esc_nxt = btd_pkg::ESC_SHOW;
                end else if (ch == btd_pkg::MARK_HIDE) begin
                  esc_nxt = btd_pkg::ESC_HIDE;
                end else begin
                  emit = 1'b1;
                end
              end
              btd_pkg::ESC_SHOW: begin
                if (ch == btd_pkg::MARK_SHOW) begin
                  esc_nxt = btd_pkg::ESC_NONE;
                end else if (ch != btd_pkg::MARK_HIDE) begin
                  emit = 1'b1;
                end
              end
              btd_pkg::ESC_HIDE: begin
                if (ch == btd_pkg::MARK_HIDE) begin
                  esc_nxt = btd_pkg::ESC_NONE;
                end
              end
              default: begin
                esc_nxt = btd_pkg::ESC_NONE;
              end
            endcase
          end
          if (emit) begin
            if (push.n == 2'd0) begin
              push.r0 = res;
            end else begin
              push.r1 = res;
            end
            push.n = push.n + 2'd1;
          end
        end
      end
    end

    // mark the final result of this byte
    if (push.n == 2'd1) begin
      push.r0.last_of_run = 1'b1;
    end else if (push.n == 2'd2) begin
      push.r1.last_of_run = 1'b1;
    end

    // nothing is pushed unless the item really moves on
    if (!fire) begin
      push.n = 2'd0;
    end
  end

endmodule

### design/btd_result_queue.sv
// result queue that takes up to two results a cycle and hands out one while out_stall is low
module btd_result_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  btd_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output btd_pkg::out_item_t out_data
);

  btd_pkg::out_item_t          q_r [btd_pkg::QUEUE_DEPTH];
  logic [btd_pkg::QPTR_W-1:0]  wr_r, wr_nxt;
  logic [btd_pkg::QPTR_W-1:0]  rd_r, rd_nxt;
  logic [btd_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pop;

  // room for a full byte worth of results
  assign room      = cnt_r <= btd_pkg::QCNT_W'(btd_pkg::QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid & ~out_stall;

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r + btd_pkg::QPTR_W'(push.n);
    rd_nxt  = rd_r + btd_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + btd_pkg::QCNT_W'(push.n) - btd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_r + btd_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

  // fill count stays within the queue
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= btd_pkg::QCNT_W'(btd_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // a push only arrives when there was room for two results
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push without room");

  // reset empties the queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> cnt_r == '0)
    else $error("queue not empty after reset");

  // no transfer and no push keeps the count
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!pop && push.n == 2'd0) |=> $stable(cnt_r))
    else $error("count moved without transfer");

endmodule

### design/bitpacked_text_decoder_unit.sv
// Packed text decoder: bytes come in on the in_ channel and are read msb first as a stream of
// 5-bit codes (code 31 takes a 6-bit extension, code 30 shifts the next letter to upper case);
// each code selects a glyph, and the emitted 7-bit characters leave on the out_ channel, with
// string_end on the result that closes a string and last_of_run on the final result of each
// byte. Characters between '/' markers are shown and between '\' markers hidden. A byte is held
// in the input register until the queue has room for two results, is decoded there and lands
// in a four-entry result queue. A byte yields zero to two results and the queue hands out one
// result per cycle while out_stall is low, so bytes are taken at one byte per cycle when they
// yield at most one result, while bytes that yield two results hold the input back.
module bitpacked_text_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  btd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output btd_pkg::out_item_t out_data
);

  btd_pkg::push_t push;
  logic           room;

  // byte decoder
  btd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // result queue
  btd_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
